// ===== hdl/poxwe_pkg.sv =====
// Shared types and constants of the pulse oximeter window estimator.
// No dependencies.
package poxwe_pkg;

   localparam int SAMPLE_W   = 18;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 18;
   localparam int PASS_W     = 2;
   localparam int SEL_W      = 3;
   localparam int THR_DIV    = 80;

   localparam logic [CSR_IDX_W-1:0] CSR_FINGER_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BPM          = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BPM          = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BPM_PER_PEAK     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPO2_OFFSET      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPO2_SLOPE       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPO2_CEILING     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPO2_FLOOR       = 4'd7;

   localparam logic [PASS_W-1:0] PASS_SUM  = 2'd0;
   localparam logic [PASS_W-1:0] PASS_DEV  = 2'd1;
   localparam logic [PASS_W-1:0] PASS_PEAK = 2'd2;

   localparam logic [SEL_W-1:0] DIV_RED_DC = 3'd0;
   localparam logic [SEL_W-1:0] DIV_IR_DC  = 3'd1;
   localparam logic [SEL_W-1:0] DIV_RED_AC = 3'd2;
   localparam logic [SEL_W-1:0] DIV_IR_AC  = 3'd3;
   localparam logic [SEL_W-1:0] DIV_THR    = 3'd4;
   localparam logic [SEL_W-1:0] DIV_SPO2   = 3'd5;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic              rd_first;
      logic [PASS_W-1:0] pass;
      logic              div_start;
      logic [SEL_W-1:0]  div_sel;
      logic              mul_a;
      logic              mul_b;
      logic              mul_c;
      logic              spo2_floor_ld;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic invalid;
      logic spo2_neg;
      logic out_hold;
   } status_type;

endpackage

// ===== hdl/poxwe_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on poxwe_pkg.
interface poxwe_req_if
   import poxwe_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] red_sample;
   logic [SAMPLE_W-1:0] ir_sample;
   modport source (output valid, red_sample, ir_sample, input ready);
   modport sink (input valid, red_sample, ir_sample, output ready);
endinterface

interface poxwe_rsp_if
   import poxwe_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] red_mean;
   logic [SAMPLE_W-1:0] ir_mean;
   logic                finger_present;
   logic                reading_valid;
   logic [BYTE_W-1:0]   heart_rate;
   logic [BYTE_W-1:0]   oxygen_saturation;
   modport source (output valid, red_mean, ir_mean, finger_present, reading_valid,
                   heart_rate, oxygen_saturation, input ready);
   modport sink (input valid, red_mean, ir_mean, finger_present, reading_valid,
                 heart_rate, oxygen_saturation, output ready);
endinterface

// ===== hdl/poxwe_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module poxwe_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/poxwe_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module poxwe_div #(
   parameter int NW = 44,
   parameter int DW = 36
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(shifted - {1'b0, dvs_ff}) : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/poxwe_ctrl.sv =====
// Controller: ring write slot, window passes, the division sequence, multiply steps and output load.
// Depends on poxwe_pkg.
module poxwe_ctrl
   import poxwe_pkg::*;
#(
   parameter int WINDOW = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic [$clog2(WINDOW)-1:0] addr,
   output cmd_type                   cmd,
   input  status_type                status
);
   localparam int AW = $clog2(WINDOW);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PASS     = 4'd1;
   localparam logic [3:0] S_PASS_END = 4'd2;
   localparam logic [3:0] S_DSTART   = 4'd3;
   localparam logic [3:0] S_DWAIT    = 4'd4;
   localparam logic [3:0] S_CHECK    = 4'd5;
   localparam logic [3:0] S_MUL_A    = 4'd6;
   localparam logic [3:0] S_MUL_B    = 4'd7;
   localparam logic [3:0] S_MUL_C    = 4'd8;
   localparam logic [3:0] S_SPO2     = 4'd9;
   localparam logic [3:0] S_FIN      = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              full_ff, full_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic              accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      full_in  = full_ff;
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.pass    = pass_ff;
      cmd.div_sel = sel_ff;
      addr     = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            addr = slot_ff;
            if (accept) begin
               cmd.wr_en = 1'b1;
               if (slot_ff == AW'(WINDOW - 1)) begin
                  slot_in = '0;
                  full_in = 1'b1;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
               if (full_in) begin
                  state_in = S_PASS;
                  pass_in  = PASS_SUM;
                  cnt_in   = '0;
               end
            end
         end
         S_PASS: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = cnt_ff == '0;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == AW'(WINDOW - 1)) begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_END: begin
            case (pass_ff)
               PASS_SUM: begin
                  sel_in   = DIV_RED_DC;
                  state_in = S_DSTART;
               end
               PASS_DEV: begin
                  sel_in   = DIV_RED_AC;
                  state_in = S_DSTART;
               end
               default: state_in = S_MUL_A;
            endcase
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) begin
               case (sel_ff)
                  DIV_RED_DC: begin
                     sel_in   = DIV_IR_DC;
                     state_in = S_DSTART;
                  end
                  DIV_IR_DC: begin
                     pass_in  = PASS_DEV;
                     cnt_in   = '0;
                     state_in = S_PASS;
                  end
                  DIV_RED_AC: begin
                     sel_in   = DIV_IR_AC;
                     state_in = S_DSTART;
                  end
                  DIV_IR_AC: state_in = S_CHECK;
                  DIV_THR: begin
                     pass_in  = PASS_PEAK;
                     cnt_in   = '0;
                     state_in = S_PASS;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_CHECK: begin
            if (status.invalid) begin
               state_in = S_FIN;
            end else begin
               sel_in   = DIV_THR;
               state_in = S_DSTART;
            end
         end
         S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_c = 1'b1;
            state_in  = S_SPO2;
         end
         S_SPO2: begin
            if (status.spo2_neg) begin
               cmd.spo2_floor_ld = 1'b1;
               state_in          = S_FIN;
            end else begin
               sel_in   = DIV_SPO2;
               state_in = S_DSTART;
            end
         end
         S_FIN: begin
            if (!status.out_hold) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= '0;
         full_ff  <= 1'b0;
         cnt_ff   <= '0;
         pass_ff  <= PASS_SUM;
         sel_ff   <= DIV_RED_DC;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         full_ff  <= full_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

// ===== hdl/poxwe_dp.sv =====
// Datapath: rings, accumulators, peak scan, multipliers, divider, CSRs, output.
// Depends on poxwe_pkg, poxwe_ram and poxwe_div.
module poxwe_dp
   import poxwe_pkg::*;
#(
   parameter int WINDOW      = 100,
   parameter int SAMPLE_BITS = 18
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [SAMPLE_W-1:0]       red_sample,
   input  logic [SAMPLE_W-1:0]       ir_sample,
   input  logic [$clog2(WINDOW)-1:0] addr,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [SAMPLE_W-1:0]       red_mean,
   output logic [SAMPLE_W-1:0]       ir_mean,
   output logic                      finger_present,
   output logic                      reading_valid,
   output logic [BYTE_W-1:0]         heart_rate,
   output logic [BYTE_W-1:0]         oxygen_saturation
);
   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(WINDOW);
   localparam int ACW = SB + $clog2(WINDOW + 1);
   localparam int VW  = 2 * SB;
   localparam int NW  = 2 * SB + BYTE_W;
   localparam int PW  = AW + BYTE_W;

   // reciprocal constants: floor(x/d) = (x*m) >> s for every x of the given width
   localparam int WS  = ACW + AW;
   localparam int WMW = ACW + 2;
   localparam int WPW = WS + SB;
   localparam logic [WMW-1:0] WIN_M = WMW'(((64'd1 << WS) / 64'(WINDOW)) + 64'd1);
   localparam int TS  = SB + $clog2(THR_DIV);
   localparam int TMW = SB + 2;
   localparam int TPW = TS + SB;
   localparam logic [TMW-1:0] THR_M = TMW'(((64'd1 << TS) / 64'(THR_DIV)) + 64'd1);

   // configuration
   logic [SAMPLE_W-1:0] finger_thr_ff;
   logic [BYTE_W-1:0]   min_bpm_ff, max_bpm_ff, bpm_per_peak_ff;
   logic [BYTE_W-1:0]   spo2_offset_ff, spo2_slope_ff, spo2_ceiling_ff, spo2_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         finger_thr_ff   <= 18'd50000;
         min_bpm_ff      <= 8'd40;
         max_bpm_ff      <= 8'd180;
         bpm_per_peak_ff <= 8'd60;
         spo2_offset_ff  <= 8'd110;
         spo2_slope_ff   <= 8'd25;
         spo2_ceiling_ff <= 8'd100;
         spo2_floor_ff   <= 8'd70;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FINGER_THRESHOLD: finger_thr_ff   <= csr_wr_data;
            CSR_MIN_BPM:          min_bpm_ff      <= csr_wr_data[BYTE_W-1:0];
            CSR_MAX_BPM:          max_bpm_ff      <= csr_wr_data[BYTE_W-1:0];
            CSR_BPM_PER_PEAK:     bpm_per_peak_ff <= csr_wr_data[BYTE_W-1:0];
            CSR_SPO2_OFFSET:      spo2_offset_ff  <= csr_wr_data[BYTE_W-1:0];
            CSR_SPO2_SLOPE:       spo2_slope_ff   <= csr_wr_data[BYTE_W-1:0];
            CSR_SPO2_CEILING:     spo2_ceiling_ff <= csr_wr_data[BYTE_W-1:0];
            CSR_SPO2_FLOOR:       spo2_floor_ff   <= csr_wr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // rings
   logic [SAMPLE_W+SB-1:0] red_ext, ir_ext;
   logic [SB-1:0]          red_rd, ir_rd;

   assign red_ext = {{SB{1'b0}}, red_sample};
   assign ir_ext  = {{SB{1'b0}}, ir_sample};

   poxwe_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_red_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (red_ext[SB-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (red_rd)
   );

   poxwe_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_ir_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (ir_ext[SB-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (ir_rd)
   );

   // window passes
   logic              dv_ff, first_ff;
   logic [PASS_W-1:0] pass_ff;
   logic [ACW-1:0]    red_acc_ff, red_acc_in, ir_acc_ff, ir_acc_in;
   logic [SB-1:0]     red_dc_ff, ir_dc_ff, red_ac_ff, ir_ac_ff;
   logic [SB:0]       thr_ff;
   logic [SB-1:0]     prev_ff, prev_in, cur_ff, cur_in;
   logic [1:0]        seen_ff, seen_in;
   logic              armed_ff, armed_in;
   logic [AW-1:0]     peaks_ff, peaks_in;
   logic [SB-1:0]     red_term, ir_term;
   logic              hit;

   always_comb begin
      red_term = red_rd;
      ir_term  = ir_rd;
      if (pass_ff == PASS_DEV) begin
         red_term = (red_rd > red_dc_ff) ? red_rd - red_dc_ff : red_dc_ff - red_rd;
         ir_term  = (ir_rd > ir_dc_ff) ? ir_rd - ir_dc_ff : ir_dc_ff - ir_rd;
      end
   end

   assign hit = !armed_ff && ({1'b0, cur_ff} > thr_ff) && (cur_ff > prev_ff)
                && (cur_ff >= ir_rd);

   always_comb begin
      red_acc_in = red_acc_ff;
      ir_acc_in  = ir_acc_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      seen_in    = seen_ff;
      armed_in   = armed_ff;
      peaks_in   = peaks_ff;
      if (dv_ff) begin
         if (pass_ff == PASS_PEAK) begin
            prev_in = cur_ff;
            cur_in  = ir_rd;
            if (first_ff) begin
               seen_in  = 2'd1;
               armed_in = 1'b0;
               peaks_in = '0;
            end else begin
               if (seen_ff != 2'd2) begin
                  seen_in = seen_ff + 2'd1;
               end else begin
                  if (hit) begin
                     peaks_in = peaks_ff + 1'b1;
                  end
                  armed_in = (cur_ff < ir_dc_ff) ? 1'b0 : (armed_ff || hit);
               end
            end
         end else begin
            red_acc_in = first_ff ? ACW'(red_term) : red_acc_ff + ACW'(red_term);
            ir_acc_in  = first_ff ? ACW'(ir_term) : ir_acc_ff + ACW'(ir_term);
         end
      end
   end

   // constant divisions (window means, threshold) by reciprocal multiplication
   logic [ACW-1:0] win_x;
   logic [WPW-1:0] win_prod_ff;
   logic [TPW-1:0] thr_prod_ff;
   logic [SB-1:0]  win_q, thr_q;
   logic           cdiv_done_ff;

   assign win_x = (cmd.div_sel == DIV_IR_DC || cmd.div_sel == DIV_IR_AC) ? ir_acc_ff
                                                                         : red_acc_ff;
   assign win_q = win_prod_ff[WS +: SB];
   assign thr_q = thr_prod_ff[TS +: SB];

   // divider, saturation quotient only
   logic [NW-1:0] div_q;
   logic          div_done, div_go, any_done;
   logic [VW-1:0] num_ff, den_ff;
   logic [NW-1:0] a_ff, b_ff, diff_ff;
   logic          neg_ff;

   assign div_go   = cmd.div_start && cmd.div_sel == DIV_SPO2;
   assign any_done = div_done || cdiv_done_ff;

   poxwe_div #(.NW(NW), .DW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (diff_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic [BYTE_W-1:0] clamp_hi, clamped;

   always_comb begin
      clamp_hi = (div_q > NW'(spo2_ceiling_ff)) ? spo2_ceiling_ff : div_q[BYTE_W-1:0];
      clamped  = (clamp_hi < spo2_floor_ff) ? spo2_floor_ff : clamp_hi;
   end

   // rate and saturation
   logic [PW-1:0]     prod_ff;
   logic [BYTE_W-1:0] rate_ff, last_rate_ff, spo2_ff;
   logic              prod_ok, last_ok;
   logic              finger, invalid;

   assign prod_ok = (prod_ff >= PW'(min_bpm_ff)) && (prod_ff <= PW'(max_bpm_ff));
   assign last_ok = (last_rate_ff >= min_bpm_ff) && (last_rate_ff <= max_bpm_ff);
   assign finger  = {{SAMPLE_W{1'b0}}, ir_dc_ff} > {{SB{1'b0}}, finger_thr_ff};
   assign invalid = !finger || red_dc_ff == '0 || ir_dc_ff == '0 || red_ac_ff == '0
                    || ir_ac_ff == '0;

   assign status.div_done = any_done;
   assign status.invalid  = invalid;
   assign status.spo2_neg = neg_ff;
   assign status.out_hold = rsp_valid && !rsp_ready;

   // output register
   logic                      out_valid_ff;
   logic [SAMPLE_W+SB-1:0]    red_dc_ext, ir_dc_ext;
   logic [SAMPLE_W-1:0]       red_mean_ff, ir_mean_ff;
   logic                      finger_ff, rdg_valid_ff;
   logic [BYTE_W-1:0]         hr_ff, sat_ff;

   assign red_dc_ext = {{SAMPLE_W{1'b0}}, red_dc_ff};
   assign ir_dc_ext  = {{SAMPLE_W{1'b0}}, ir_dc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= 1'b0;
         cdiv_done_ff <= 1'b0;
         last_rate_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         dv_ff        <= cmd.rd_en;
         cdiv_done_ff <= cmd.div_start && cmd.div_sel != DIV_SPO2;
         if (cmd.out_load) begin
            last_rate_ff <= invalid ? '0 : rate_ff;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      first_ff   <= cmd.rd_first;
      pass_ff    <= cmd.pass;
      red_acc_ff <= red_acc_in;
      ir_acc_ff  <= ir_acc_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      seen_ff    <= seen_in;
      armed_ff   <= armed_in;
      peaks_ff   <= peaks_in;
      if (cmd.div_start) begin
         win_prod_ff <= WPW'(win_x) * WPW'(WIN_M);
         thr_prod_ff <= TPW'(ir_dc_ff) * TPW'(THR_M);
      end
      if (any_done) begin
         case (cmd.div_sel)
            DIV_RED_DC: red_dc_ff <= win_q;
            DIV_IR_DC:  ir_dc_ff  <= win_q;
            DIV_RED_AC: red_ac_ff <= win_q;
            DIV_IR_AC:  ir_ac_ff  <= win_q;
            DIV_THR:    thr_ff    <= {1'b0, ir_dc_ff} + {1'b0, thr_q};
            DIV_SPO2:   spo2_ff   <= clamped;
            default: ;
         endcase
      end
      if (cmd.spo2_floor_ld) begin
         spo2_ff <= spo2_floor_ff;
      end
      if (cmd.mul_a) begin
         num_ff  <= VW'(red_ac_ff) * VW'(ir_dc_ff);
         den_ff  <= VW'(red_dc_ff) * VW'(ir_ac_ff);
         prod_ff <= PW'(peaks_ff) * PW'(bpm_per_peak_ff);
      end
      if (cmd.mul_b) begin
         a_ff    <= NW'(spo2_offset_ff) * NW'(den_ff);
         b_ff    <= NW'(spo2_slope_ff) * NW'(num_ff);
         rate_ff <= prod_ok ? prod_ff[BYTE_W-1:0] : (last_ok ? last_rate_ff : '0);
      end
      if (cmd.mul_c) begin
         diff_ff <= a_ff - b_ff;
         neg_ff  <= a_ff < b_ff;
      end
      if (cmd.out_load) begin
         red_mean_ff  <= red_dc_ext[SAMPLE_W-1:0];
         ir_mean_ff   <= ir_dc_ext[SAMPLE_W-1:0];
         finger_ff    <= finger;
         rdg_valid_ff <= !invalid && rate_ff != '0;
         hr_ff        <= invalid ? '0 : rate_ff;
         sat_ff       <= invalid ? '0 : spo2_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign red_mean          = red_mean_ff;
   assign ir_mean           = ir_mean_ff;
   assign finger_present    = finger_ff;
   assign reading_valid     = rdg_valid_ff;
   assign heart_rate        = hr_ff;
   assign oxygen_saturation = sat_ff;
endmodule

// ===== hdl/pulse_oximeter_window_estimator_unit.sv =====
// Pulse oximeter window estimator, top level: controller plus datapath.
// Depends on poxwe_pkg, poxwe_if, poxwe_ctrl and poxwe_dp.
// Until the rings first fill, a request gives no response and the unit stays ready.
// After that a request runs three ring passes at one entry per cycle, means and threshold
// by reciprocal multiply and one SpO2 division at one bit per cycle; an invalid reading skips
// the threshold, peak pass and division. No new request is taken until the result is loaded.
// Reset is synchronous, active high; ring contents stay undefined until written.
module pulse_oximeter_window_estimator_unit
   import poxwe_pkg::*;
#(
   parameter int WINDOW      = 100,
   parameter int SAMPLE_BITS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   poxwe_req_if.sink             req_chan,
   poxwe_rsp_if.source           rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   logic [$clog2(WINDOW)-1:0] addr;
   cmd_type                   cmd;
   status_type                status;

   poxwe_ctrl #(.WINDOW(WINDOW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .addr      (addr),
      .cmd       (cmd),
      .status    (status)
   );

   poxwe_dp #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .red_sample        (req_chan.red_sample),
      .ir_sample         (req_chan.ir_sample),
      .addr              (addr),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .red_mean          (rsp_chan.red_mean),
      .ir_mean           (rsp_chan.ir_mean),
      .finger_present    (rsp_chan.finger_present),
      .reading_valid     (rsp_chan.reading_valid),
      .heart_rate        (rsp_chan.heart_rate),
      .oxygen_saturation (rsp_chan.oxygen_saturation)
   );
endmodule

// ===== tb/tb_pulse_oximeter_window_estimator_unit.sv =====
// Self-checking testbench of pulse_oximeter_window_estimator_unit: predicts
// window means, deviations, peak-count rate and SpO2 per request and checks the responses.
// Depends on poxwe_pkg, poxwe_if and the unit's RTL.
module tb_pulse_oximeter_window_estimator_unit;
   import poxwe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = 100;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] ir;
   } sample_t;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red_mean;
      logic [SAMPLE_W-1:0] ir_mean;
      logic                finger;
      logic                valid;
      logic [BYTE_W-1:0]   rate;
      logic [BYTE_W-1:0]   spo2;
   } reading_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   poxwe_req_if req_chan();
   poxwe_rsp_if rsp_chan();

   pulse_oximeter_window_estimator_unit i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [SAMPLE_W-1:0] red_ring [WIN];
   logic [SAMPLE_W-1:0] ir_ring [WIN];
   int unsigned slot, last_rate;
   bit full;
   int unsigned cfg [8];

   sample_t  pending_q[$];
   reading_t expected_q[$];
   int errors, n_req, n_rsp, n_valid;
   bit burst_on;
   bit req_taken;
   int burst_left;
   int stall_phase;

   function automatic int unsigned ring_mean(input logic [SAMPLE_W-1:0] r [WIN]);
      longint unsigned s;
      s = 0;
      for (int i = 0; i < WIN; i++) s += r[i];
      return 32'(s / WIN);
   endfunction

   function automatic int unsigned ring_dev(input logic [SAMPLE_W-1:0] r [WIN],
                                            input int unsigned dc);
      longint unsigned s;
      s = 0;
      for (int i = 0; i < WIN; i++) s += (r[i] > dc) ? r[i] - dc : dc - r[i];
      return 32'(s / WIN);
   endfunction

   function automatic int unsigned count_peaks(input int unsigned dc);
      int unsigned thr, cnt;
      bit armed;
      thr = dc + dc / THR_DIV;
      cnt = 0;
      armed = 0;
      for (int i = 1; i + 1 < WIN; i++) begin
         if (!armed && ir_ring[i] > thr && ir_ring[i] > ir_ring[i-1]
             && ir_ring[i] >= ir_ring[i+1]) begin
            cnt++;
            armed = 1;
         end
         if (ir_ring[i] < dc) armed = 0;
      end
      return cnt;
   endfunction

   task automatic predict_reading(input sample_t s);
      int unsigned rdc, idc, rac, iac, rate;
      longint unsigned num, den, a, b, q;
      reading_t e;
      red_ring[slot] = s.red;
      ir_ring[slot] = s.ir;
      slot++;
      if (slot >= WIN) begin
         slot = 0;
         full = 1;
      end
      if (!full) return;
      rdc = ring_mean(red_ring);
      idc = ring_mean(ir_ring);
      rac = ring_dev(red_ring, rdc);
      iac = ring_dev(ir_ring, idc);
      e = '0;
      e.red_mean = SAMPLE_W'(rdc);
      e.ir_mean = SAMPLE_W'(idc);
      e.finger = idc > cfg[CSR_FINGER_THRESHOLD];
      if (!e.finger || rdc == 0 || idc == 0 || rac == 0 || iac == 0) begin
         last_rate = 0;
      end else begin
         rate = count_peaks(idc) * cfg[CSR_BPM_PER_PEAK];
         if (rate < cfg[CSR_MIN_BPM] || rate > cfg[CSR_MAX_BPM])
            rate = (last_rate >= cfg[CSR_MIN_BPM] && last_rate <= cfg[CSR_MAX_BPM])
                   ? last_rate : 0;
         num = longint'(rac) * idc;
         den = longint'(rdc) * iac;
         a = cfg[CSR_SPO2_OFFSET] * den;
         b = cfg[CSR_SPO2_SLOPE] * num;
         if (a >= b) begin
            q = (a - b) / den;
            if (q > cfg[CSR_SPO2_CEILING]) q = cfg[CSR_SPO2_CEILING];
            if (q < cfg[CSR_SPO2_FLOOR]) q = cfg[CSR_SPO2_FLOOR];
         end else begin
            q = cfg[CSR_SPO2_FLOOR];
         end
         last_rate = rate & 8'hFF;
         e.valid = rate > 0;
         e.rate = BYTE_W'(rate);
         e.spo2 = BYTE_W'(q);
      end
      expected_q.push_back(e);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (burst_left == 0) begin
            burst_on = !burst_on;
            burst_left = burst_on ? $urandom_range(1, 40) : $urandom_range(0, 6);
         end
         if (burst_left > 0) burst_left--;
         if (burst_on && pending_q.size() > 0) begin
            sample_t s;
            s = pending_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.red_sample <= s.red;
            req_chan.ir_sample <= s.ir;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 64;
      rsp_chan.ready <= (stall_phase < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         predict_reading('{red: req_chan.red_sample, ir: req_chan.ir_sample});
         n_req++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         reading_t act, e;
         act = '{rsp_chan.red_mean, rsp_chan.ir_mean, rsp_chan.finger_present,
                 rsp_chan.reading_valid, rsp_chan.heart_rate,
                 rsp_chan.oxygen_saturation};
         n_rsp++;
         if (act.valid) n_valid++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, act);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (act !== e) begin
               errors++;
               $display("%0t: mismatch expected rm=%0d im=%0d f=%0d v=%0d hr=%0d sp=%0d",
                        $time, e.red_mean, e.ir_mean, e.finger, e.valid, e.rate, e.spo2);
               $display("%0t:          actual rm=%0d im=%0d f=%0d v=%0d hr=%0d sp=%0d",
                        $time, act.red_mean, act.ir_mean, act.finger, act.valid,
                        act.rate, act.spo2);
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= CSR_DATA_W'(val);
      if (idx < 8) cfg[idx] = (idx == CSR_FINGER_THRESHOLD) ? val & 18'h3FFFF : val & 8'hFF;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || expected_q.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (800) @(posedge clock);
   endtask

   // pulse-shaped window: baseline plus periodic peaks and noise
   task automatic queue_pulses(input int n, input int unsigned base, input int period,
                               input int unsigned amp, input int noise);
      int unsigned ph, rb;
      ph = $urandom_range(0, period - 1);
      rb = base / 2 + $urandom_range(0, base);
      for (int i = 0; i < n; i++) begin
         int unsigned w, k;
         k = (i + ph) % period;
         w = (k < period / 2) ? k : period - k;
         pending_q.push_back('{red: (rb + w * amp / 3 + $urandom_range(0, noise))
                                    & 18'h3FFFF,
                               ir: (base + w * amp + $urandom_range(0, noise))
                                    & 18'h3FFFF});
      end
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         pending_q.push_back('{red: $urandom_range(0, 18'h3FFFF),
                               ir: $urandom_range(0, 18'h3FFFF)});
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.red_sample = '0;
      req_chan.ir_sample = '0;
      rsp_chan.ready = 1'b0;
      cfg = '{50000, 40, 180, 60, 110, 25, 100, 70};
      slot = 0;
      full = 0;
      last_rate = 0;
      errors = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: extremes (all-zero and all-max samples) mixed into a constant baseline
      for (int i = 0; i < 8; i++)
         pending_q.push_back('{red: (i % 2) ? 18'h3FFFF : 18'h0,
                               ir: (i % 2) ? 18'h3FFFF : 18'h0});
      for (int i = 0; i < 92; i++) pending_q.push_back('{red: 18'h1000, ir: 18'h20000});
      pending_q.push_back('{red: 18'h0, ir: 18'h0});
      pending_q.push_back('{red: 18'h3FFFF, ir: 18'h3FFFF});
      for (int i = 0; i < 12; i++) pending_q.push_back('{red: 18'h1000, ir: 18'h20000});
      queue_pulses(20, 100000, 25, 500, 50);
      wait_idle();
      // random phases across settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_FINGER_THRESHOLD, 0);
               write_csr(CSR_BPM_PER_PEAK, 1);
               write_csr(CSR_MIN_BPM, 0);
               write_csr(CSR_MAX_BPM, 255);
            end
            1: begin
               write_csr(CSR_FINGER_THRESHOLD, 18'h3FFFF);
               write_csr(CSR_BPM_PER_PEAK, 255);
               write_csr(CSR_SPO2_OFFSET, 255);
               write_csr(CSR_SPO2_SLOPE, 0);
            end
            2: begin
               write_csr(CSR_FINGER_THRESHOLD, 1000);
               write_csr(CSR_BPM_PER_PEAK, 20);
               write_csr(CSR_MIN_BPM, 255);
               write_csr(CSR_MAX_BPM, 0);
               write_csr(CSR_SPO2_CEILING, 50);
               write_csr(CSR_SPO2_FLOOR, 90);
            end
            3: begin
               write_csr(CSR_MIN_BPM, 20);
               write_csr(CSR_MAX_BPM, 120);
               write_csr(CSR_SPO2_OFFSET, 0);
               write_csr(CSR_SPO2_SLOPE, 255);
               write_csr(CSR_SPO2_CEILING, 255);
               write_csr(CSR_SPO2_FLOOR, 0);
               write_csr(4'd9, 123);
            end
            4: begin
               write_csr(CSR_SPO2_OFFSET, 110);
               write_csr(CSR_SPO2_SLOPE, 25);
               write_csr(CSR_SPO2_CEILING, 100);
               write_csr(CSR_SPO2_FLOOR, 70);
               write_csr(CSR_BPM_PER_PEAK, $urandom_range(1, 60));
            end
            default: begin
               write_csr(CSR_FINGER_THRESHOLD, $urandom_range(0, 150000));
               write_csr(CSR_MIN_BPM, $urandom_range(0, 80));
               write_csr(CSR_MAX_BPM, $urandom_range(80, 255));
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 4) == 0) queue_random(20);
            else queue_pulses(20, $urandom_range(0, 250000), $urandom_range(4, 40),
                              $urandom_range(0, 800), $urandom_range(0, 300));
         end
         wait_idle();
      end
      $display("Run covered %0d requests, %0d responses, %0d with a valid rate.",
               n_req, n_rsp, n_valid);
      if (errors == 0) $display("tb_pulse_oximeter_window_estimator_unit OK");
      else $display("tb_pulse_oximeter_window_estimator_unit NOT OK");
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout");
      $display("tb_pulse_oximeter_window_estimator_unit NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/poxwe_pkg.sv
hdl/poxwe_if.sv
hdl/poxwe_ram.sv
hdl/poxwe_div.sv
hdl/poxwe_ctrl.sv
hdl/poxwe_dp.sv
hdl/pulse_oximeter_window_estimator_unit.sv
tb/tb_pulse_oximeter_window_estimator_unit.sv
